/* sv/sjf_pkg.sv */
`default_nettype none

package sjf_pkg;

  localparam int unsigned MaxJobsDefault = 64;
  localparam int unsigned FieldW = 16;
  localparam int unsigned TimeW = 23;

  typedef struct packed {
    logic [FieldW-1:0] id;
    logic [FieldW-1:0] arr;
    logic [FieldW-1:0] burst;
  } job_t;

  typedef struct packed {
    logic found;
    job_t job;
  } cand_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage

`default_nettype wire

/* sv/sjf_ram.sv */
`default_nettype none

module sjf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/sjf_select.sv */
`default_nettype none

module sjf_select import sjf_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       chk_vld_i,
  input  logic [$clog2(MaxJobs)-1:0] chk_idx_i,
  input  logic                       sched_i,
  input  logic [TimeW-1:0]           cur_time_i,
  input  job_t                       entry_i,
  output cand_t                      ready_o,
  output logic [$clog2(MaxJobs)-1:0] ready_idx_o,
  output cand_t                      pend_o,
  output logic [$clog2(MaxJobs)-1:0] pend_idx_o
);

  localparam int unsigned IdxW = $clog2(MaxJobs);

  cand_t           ready_q, pend_q;
  logic [IdxW-1:0] ready_idx_q, pend_idx_q;
  logic            arrived, ready_better, pend_better;

  // Ready jobs order by burst, arrival, id; pending jobs by arrival, burst, id.
  // Strict compares keep the earlier entry on a full tie.
  assign arrived = {{(TimeW-FieldW){1'b0}}, entry_i.arr} <= cur_time_i;
  assign ready_better = !ready_q.found ||
      ({entry_i.burst, entry_i.arr, entry_i.id} <
       {ready_q.job.burst, ready_q.job.arr, ready_q.job.id});
  assign pend_better = !pend_q.found ||
      ({entry_i.arr, entry_i.burst, entry_i.id} <
       {pend_q.job.arr, pend_q.job.burst, pend_q.job.id});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= '0;
      pend_q      <= '0;
      ready_idx_q <= '0;
      pend_idx_q  <= '0;
    end else if (clear_i) begin
      ready_q.found <= 1'b0;
      pend_q.found  <= 1'b0;
    end else if (chk_vld_i && !sched_i) begin
      if (arrived && ready_better) begin
        ready_q     <= '{found: 1'b1, job: entry_i};
        ready_idx_q <= chk_idx_i;
      end
      if (pend_better) begin
        pend_q     <= '{found: 1'b1, job: entry_i};
        pend_idx_q <= chk_idx_i;
      end
    end
  end

  assign ready_o     = ready_q;
  assign ready_idx_o = ready_idx_q;
  assign pend_o      = pend_q;
  assign pend_idx_o  = pend_idx_q;

endmodule

`default_nettype wire

/* sv/sjf_nonpreemptive_scheduler_core.sv */
`default_nettype none

// Non-preemptive shortest-job-first scheduler. Job records are loaded one item
// per cycle while busy_o is low; the item with last_item_i set starts scheduling
// and busy_o stays high until the whole schedule has been sent. Each scheduled
// job id appears for exactly one cycle with valid_o high and must be taken then,
// since the receiver cannot stall the block. Each result needs one full scan of
// the job memory through its single read port, a wait state for the last read
// to land in the compare stage, and a pick state to commit the pick. Records
// beyond MaxJobs are dropped and reported on overflow_o with every result of
// that batch.
module sjf_nonpreemptive_scheduler_core import sjf_pkg::*; #(
  parameter int unsigned MaxJobs = MaxJobsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [FieldW-1:0] job_id_i,
  input  logic [FieldW-1:0] arrival_time_i,
  input  logic [FieldW-1:0] burst_time_i,
  input  logic              last_item_i,
  output logic              valid_o,
  output logic [FieldW-1:0] sched_job_id_o,
  output logic              last_result_o,
  output logic              overflow_o
);

  localparam int unsigned IdxW = $clog2(MaxJobs);
  localparam int unsigned CntW = $clog2(MaxJobs + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait,
    StPick
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q, k_q;
  logic [IdxW-1:0]    ptr_q, chk_idx_q;
  logic               chk_vld_q;
  logic [TimeW-1:0]   time_q;
  logic               ovf_q;
  logic               valid_q, last_q, out_ovf_q;
  logic [FieldW-1:0]  out_id_q;

  logic              accept, store_full, load_we, ram_we, ram_re;
  logic [CntW-1:0]   cnt_m1, k_p1;
  job_t              wr_job, rd_job, pick_job;
  logic [JobW:0]     ram_wdata, rd_word;
  logic [IdxW-1:0]   ram_waddr;
  cand_t             ready, pend;
  logic [IdxW-1:0]   ready_idx, pend_idx, pick_idx;
  logic [TimeW-1:0]  base_time, time_d;

  // Each memory word carries a scheduled flag above the job record. Loading
  // writes the flag clear, and every pick writes its entry back with the flag set.
  assign accept     = start_i && (state_q == StIdle);
  assign store_full = (count_q == CntW'(MaxJobs));
  assign load_we    = accept && !store_full;
  assign ram_we     = load_we || (state_q == StPick);
  assign ram_waddr  = load_we ? count_q[IdxW-1:0] : pick_idx;
  assign ram_wdata  = load_we ? {1'b0, wr_job} : {1'b1, pick_job};
  assign ram_re     = (state_q == StScan);
  assign cnt_m1     = count_q - CntW'(1);
  assign k_p1       = k_q + CntW'(1);
  assign wr_job     = '{id: job_id_i, arr: arrival_time_i, burst: burst_time_i};
  assign rd_job     = rd_word[JobW-1:0];

  sjf_ram #(
    .Width(JobW + 1),
    .Depth(MaxJobs)
  ) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ptr_q),
    .rdata_o(rd_word)
  );

  sjf_select #(
    .MaxJobs(MaxJobs)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (state_q == StPick),
    .chk_vld_i  (chk_vld_q),
    .chk_idx_i  (chk_idx_q),
    .sched_i    (rd_word[JobW]),
    .cur_time_i (time_q),
    .entry_i    (rd_job),
    .ready_o    (ready),
    .ready_idx_o(ready_idx),
    .pend_o     (pend),
    .pend_idx_o (pend_idx)
  );

  always_comb begin
    if (ready.found) begin
      pick_job  = ready.job;
      pick_idx  = ready_idx;
      base_time = time_q;
    end else begin
      pick_job  = pend.job;
      pick_idx  = pend_idx;
      base_time = {{(TimeW-FieldW){1'b0}}, pend.job.arr};
    end
    time_d = base_time + {{(TimeW-FieldW){1'b0}}, pick_job.burst};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      k_q       <= '0;
      ptr_q     <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      time_q    <= '0;
      ovf_q     <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
      out_ovf_q <= 1'b0;
      out_id_q  <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          chk_vld_q <= 1'b0;
          if (accept) begin
            if (store_full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CntW'(1);
            end
            if (last_item_i) begin
              ptr_q   <= '0;
              k_q     <= '0;
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          chk_vld_q <= 1'b1;
          chk_idx_q <= ptr_q;
          ptr_q     <= ptr_q + IdxW'(1);
          if (ptr_q == cnt_m1[IdxW-1:0]) begin
            state_q <= StWait;
          end
        end
        StWait: begin
          chk_vld_q <= 1'b0;
          state_q   <= StPick;
        end
        StPick: begin
          valid_q   <= 1'b1;
          out_id_q  <= pick_job.id;
          out_ovf_q <= ovf_q;
          ptr_q     <= '0;
          k_q       <= k_p1;
          if (k_p1 == count_q) begin
            last_q  <= 1'b1;
            count_q <= '0;
            time_q  <= '0;
            ovf_q   <= 1'b0;
            state_q <= StIdle;
          end else begin
            last_q  <= 1'b0;
            time_q  <= time_d;
            state_q <= StScan;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign valid_o        = valid_q;
  assign sched_job_id_o = out_id_q;
  assign last_result_o  = last_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

/* tb/sv/sjf_nonpreemptive_scheduler_core_test.sv */
`timescale 1ns / 100ps

module sjf_nonpreemptive_scheduler_core_test import sjf_pkg::*;;

  localparam int unsigned Cap = MaxJobsDefault;

  typedef struct {
    logic [FieldW-1:0] id;
    logic              last;
    logic              ovf;
  } sched_t;

  class sjf_scoreboard;
    job_t        jobs[Cap];
    int unsigned n_stored;
    bit          dropped;
    sched_t      pending_q[$];
    int unsigned n_errors;
    int unsigned n_results;
    int unsigned n_batches;
    int unsigned n_jobs;
    int unsigned n_dropped;

    function bit runs_first(job_t a, job_t b);
      if (a.burst != b.burst) return a.burst < b.burst;
      if (a.arr != b.arr) return a.arr < b.arr;
      return a.id < b.id;
    endfunction

    function void report(string what, sched_t want, logic [FieldW-1:0] id, logic last,
                         logic ovf);
      n_errors++;
      if (n_errors <= 10)
        $display("%s: expected id=%h last=%b ovf=%b, got id=%h last=%b ovf=%b",
                 what, want.id, want.last, want.ovf, id, last, ovf);
    endfunction

    function void schedule_batch();
      bit               done[Cap];
      logic [TimeW-1:0] now;
      logic [TimeW-1:0] earliest;
      bit               ready;
      int               best;
      sched_t           s;
      now = '0;
      for (int i = 0; i < Cap; i++) done[i] = 1'b0;
      for (int k = 0; k < int'(n_stored); k++) begin
        ready = 1'b0;
        earliest = '1;
        for (int i = 0; i < int'(n_stored); i++) begin
          if (!done[i] && jobs[i].arr <= now) ready = 1'b1;
          if (!done[i] && jobs[i].arr < earliest) earliest = jobs[i].arr;
        end
        if (!ready) now = earliest;
        best = -1;
        for (int i = 0; i < int'(n_stored); i++) begin
          if (done[i] || jobs[i].arr > now) continue;
          if (best < 0 || runs_first(jobs[i], jobs[best])) best = i;
        end
        done[best] = 1'b1;
        now = now + jobs[best].burst;
        s.id = jobs[best].id;
        s.last = (k == int'(n_stored) - 1);
        s.ovf = dropped;
        pending_q = {pending_q, s};
      end
      n_stored = 0;
      dropped = 1'b0;
      n_batches++;
    endfunction

    function void note_job(job_t j, logic last);
      n_jobs++;
      if (n_stored < Cap) begin
        jobs[n_stored] = j;
        n_stored++;
      end else begin
        dropped = 1'b1;
        n_dropped++;
      end
      if (last) schedule_batch();
    endfunction

    function void check_result(logic [FieldW-1:0] id, logic last, logic ovf);
      sched_t want;
      n_results++;
      if (pending_q.size() == 0) begin
        want.id = 'x;
        want.last = 1'bx;
        want.ovf = 1'bx;
        report("Unexpected result", want, id, last, ovf);
        return;
      end
      want = pending_q.pop_front();
      if (want.id !== id || want.last !== last || want.ovf !== ovf)
        report("Mismatch", want, id, last, ovf);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [FieldW-1:0] job_id_i = '0;
  logic [FieldW-1:0] arrival_time_i = '0;
  logic [FieldW-1:0] burst_time_i = '0;
  logic              last_item_i = 1'b0;
  logic              valid_o;
  logic [FieldW-1:0] sched_job_id_o;
  logic              last_result_o;
  logic              overflow_o;

  sjf_scoreboard sb;

  sjf_nonpreemptive_scheduler_core u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .job_id_i,
    .arrival_time_i,
    .burst_time_i,
    .last_item_i,
    .valid_o,
    .sched_job_id_o,
    .last_result_o,
    .overflow_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[sjf_nonpreemptive_scheduler_core] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) sb.check_result(sched_job_id_o, last_result_o, overflow_o);
  end

  task automatic send_job(input logic [FieldW-1:0] id, input logic [FieldW-1:0] arr,
                          input logic [FieldW-1:0] burst, input logic last, input bit eager);
    int unsigned gap;
    job_t        j;
    gap = eager ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    job_id_i <= id;
    arrival_time_i <= arr;
    burst_time_i <= burst;
    last_item_i <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    j.id = id;
    j.arr = arr;
    j.burst = burst;
    sb.note_job(j, last);
  endtask

  function automatic logic [FieldW-1:0] pick_value(int unsigned flavor, int unsigned lim);
    case (flavor)
      0: return FieldW'($urandom_range(0, 65535));
      1: return FieldW'($urandom_range(0, lim));
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          default: return FieldW'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned items;
    int unsigned size;
    int unsigned flavor;
    int unsigned b;
    bit          eager;
    sb = new;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single records with the smallest and the largest values.
    send_job(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    // Ties on burst broken by arrival and then by id, then an idle gap.
    send_job(16'd5, 16'd0, 16'd10, 1'b0, 1'b0);
    send_job(16'd3, 16'd2, 16'd1, 1'b0, 1'b1);
    send_job(16'd4, 16'd2, 16'd1, 1'b0, 1'b0);
    send_job(16'd9, 16'd1, 16'd1, 1'b0, 1'b1);
    send_job(16'd7, 16'd50, 16'd3, 1'b1, 1'b0);
    // Identical records, with nothing ready at time zero.
    send_job(16'd2, 16'd4, 16'd6, 1'b0, 1'b0);
    send_job(16'd2, 16'd4, 16'd6, 1'b0, 1'b0);
    send_job(16'd2, 16'd4, 16'd6, 1'b0, 1'b1);
    send_job(16'd1, 16'd4, 16'd7, 1'b1, 1'b0);
    // Several jobs share the earliest arrival after an idle stretch.
    send_job(16'd8, 16'd100, 16'd5, 1'b0, 1'b0);
    send_job(16'd6, 16'd100, 16'd5, 1'b0, 1'b0);
    send_job(16'd1, 16'd100, 16'd9, 1'b0, 1'b1);
    send_job(16'd2, 16'd200, 16'd0, 1'b1, 1'b0);
    send_job(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_job(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_job(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1);

    items = 0;
    b = 0;
    while (items < 320) begin
      size = (b % 25 == 5) ? $urandom_range(62, 68) : $urandom_range(1, 8);
      flavor = $urandom_range(0, 2);
      eager = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < size; i++)
        send_job(pick_value(flavor, 15), pick_value(flavor, 40), pick_value(flavor, 12),
                 i == size - 1, eager);
      items += size;
      b++;
    end
    start_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4 * (Cap + 2)) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      sb.n_errors++;
      $display("%0d scheduled results never arrived", sb.pending_q.size());
    end

    $display("Ran %0d batches from %0d job records, %0d of them dropped on a full store.",
             sb.n_batches, sb.n_jobs, sb.n_dropped);
    $display("Checked %0d scheduled results, %0d failures.", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("[sjf_nonpreemptive_scheduler_core] OK");
    end else begin
      $display("[sjf_nonpreemptive_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sjf_pkg.sv
sv/sjf_ram.sv
sv/sjf_select.sv
sv/sjf_nonpreemptive_scheduler_core.sv
tb/sv/sjf_nonpreemptive_scheduler_core_test.sv
